### rtl/lpga_pkg.sv
// Shared types, field widths, command codes and datapath operations.
`default_nettype none

package lpga_pkg;

    // Parameter defaults for the top level
    localparam int DEF_MAX_NODES  = 16;
    localparam int DEF_LABEL_BITS = 16;

    // Fixed field widths
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 8;
    localparam int LABEL_W    = 16;
    localparam int SIZE_W     = 5;
    localparam int NODE_OUT_W = 5;
    localparam int CNT_W      = 9;
    localparam int LIST_AW    = 8;
    localparam int LIST_CAP   = 256;
    localparam int REG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int DIM_W      = 2 * SIZE_W;
    localparam int DIV_CNT_W  = $clog2(IDX_W);
    localparam int SIZE_RESET = 16;

    // Stream payload widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_LOAD_A   = 3'd0;
    localparam t_cmd CMD_LOAD_B   = 3'd1;
    localparam t_cmd CMD_FINALIZE = 3'd2;
    localparam t_cmd CMD_QUERY    = 3'd3;
    localparam t_cmd CMD_PAIR     = 3'd4;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_MODE   = 2'd0;
    localparam t_reg_idx REG_SIZE_A = 2'd1;
    localparam t_reg_idx REG_SIZE_B = 2'd2;

    // One operation per cycle from the controller to the datapath
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_DIV_STEP,
        OP_RD_IK,
        OP_RD_JL,
        OP_RD_EDGE,
        OP_FULL_RES,
        OP_RD_LIST_HI,
        OP_RD_LIST_LO,
        OP_RD_PAIR_EDGE,
        OP_CMP_RES,
        OP_RD_LIST_ROW,
        OP_PAIR_RES,
        OP_FIN_START,
        OP_FIN_RD_A,
        OP_FIN_RD_B,
        OP_FIN_CMP,
        OP_FIN_END,
        OP_RES_BASIC
    } t_dp_op;

    // Status from the datapath back to the controller
    typedef struct packed {
        t_cmd cmd;
        logic mode;
        logic err;
        logic same_idx;
        logic fin_b_last;
        logic fin_a_last;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/lpga_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lpga_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/lpga_dp.sv
// Datapath: configuration, label stores, pair list, divider and result registers.
`default_nettype none

module lpga_dp #(
    parameter int MAX_NODES  = lpga_pkg::DEF_MAX_NODES,
    parameter int LABEL_BITS = lpga_pkg::DEF_LABEL_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lpga_pkg::REG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lpga_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [lpga_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [lpga_pkg::IDX_W-1:0]          i_row,
    input  wire logic [lpga_pkg::IDX_W-1:0]          i_col,
    input  wire logic signed [lpga_pkg::LABEL_W-1:0] i_label,
    input  wire lpga_pkg::t_dp_op                    i_op,
    output lpga_pkg::t_dp_status                     o_status,
    output logic signed [lpga_pkg::LABEL_W-1:0]      o_value,
    output logic [lpga_pkg::CNT_W-1:0]               o_pair_count,
    output logic [lpga_pkg::NODE_OUT_W-1:0]          o_node_a,
    output logic [lpga_pkg::NODE_OUT_W-1:0]          o_node_b,
    output logic                                     o_error
);

    import lpga_pkg::*;

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int AW     = $clog2(DEPTH);
    localparam int LB     = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
    localparam int LW     = 2 * NODE_W;

    // Configuration and list bookkeeping
    logic              r_mode;
    logic [SIZE_W-1:0] r_size_a;
    logic [SIZE_W-1:0] r_size_b;
    logic [CNT_W-1:0]  r_pair_total;
    logic              r_list_ready;

    // Latched request
    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [LB-1:0]     r_label;

    // Bit-serial dividers for row and column by the size of B
    logic [IDX_W-1:0]  r_quo_r;
    logic [SIZE_W-1:0] r_rem_r;
    logic [IDX_W-1:0]  r_quo_c;
    logic [SIZE_W-1:0] r_rem_c;

    logic              r_match_ik;
    logic              r_match_jl;
    logic [LW-1:0]     r_hi_pair;
    logic [NODE_W-1:0] r_fin_a;
    logic [NODE_W-1:0] r_fin_b;
    logic [CNT_W-1:0]  r_fin_cnt;

    logic signed [LABEL_W-1:0] r_out_value;
    logic [CNT_W-1:0]          r_out_count;
    logic [NODE_OUT_W-1:0]     r_out_node_a;
    logic [NODE_OUT_W-1:0]     r_out_node_b;
    logic                      r_out_err;

    logic [SIZE_W-1:0]  na;
    logic [SIZE_W-1:0]  nb;
    logic [DIM_W-1:0]   dim;
    logic               err;
    logic [IDX_W-1:0]   idx_hi;
    logic [IDX_W-1:0]   idx_lo;
    logic [NODE_W-1:0]  node_i;
    logic [NODE_W-1:0]  node_j;
    logic [NODE_W-1:0]  node_k;
    logic [NODE_W-1:0]  node_l;
    logic [SIZE_W:0]    trial_r;
    logic [SIZE_W:0]    trial_c;
    logic               ge_r;
    logic               ge_c;
    logic [SIZE_W-1:0]  rem_next_r;
    logic [SIZE_W-1:0]  rem_next_c;

    logic               a_we;
    logic               b_we;
    logic [AW-1:0]      ab_waddr;
    logic               a_re;
    logic               b_re;
    logic [AW-1:0]      a_raddr;
    logic [AW-1:0]      b_raddr;
    logic [LB-1:0]      a_rdata;
    logic [LB-1:0]      b_rdata;
    logic               list_we;
    logic               list_re;
    logic [LIST_AW-1:0] list_raddr;
    logic [LW-1:0]      list_rdata;
    logic               labels_eq;
    logic               a_positive;
    logic signed [LABEL_W-1:0] a_sext;

    function automatic logic [AW-1:0] f_addr(input logic [NODE_W-1:0] r,
                                             input logic [NODE_W-1:0] c);
        return AW'(32'(r) * MAX_NODES + 32'(c));
    endfunction

    // Sizes outside the legal range are clamped
    always_comb begin
        na = (r_size_a == '0) ? SIZE_W'(1)
           : ((32'(r_size_a) > MAX_NODES) ? SIZE_W'(MAX_NODES) : r_size_a);
        nb = (r_size_b == '0) ? SIZE_W'(1)
           : ((32'(r_size_b) > MAX_NODES) ? SIZE_W'(MAX_NODES) : r_size_b);
        dim = DIM_W'(na) * DIM_W'(nb);
    end

    assign idx_hi = (r_row > r_col) ? r_row : r_col;
    assign idx_lo = (r_row > r_col) ? r_col : r_row;

    // Quotient is the node of the outer graph, remainder the node of B
    assign node_i = NODE_W'(r_quo_r);
    assign node_k = NODE_W'(r_rem_r);
    assign node_j = NODE_W'(r_quo_c);
    assign node_l = NODE_W'(r_rem_c);

    assign trial_r    = {r_rem_r, r_quo_r[IDX_W-1]};
    assign trial_c    = {r_rem_c, r_quo_c[IDX_W-1]};
    assign ge_r       = trial_r >= {1'b0, nb};
    assign ge_c       = trial_c >= {1'b0, nb};
    assign rem_next_r = ge_r ? SIZE_W'(trial_r - {1'b0, nb}) : SIZE_W'(trial_r);
    assign rem_next_c = ge_c ? SIZE_W'(trial_c - {1'b0, nb}) : SIZE_W'(trial_c);

    // Request error, decided from the latched fields
    always_comb begin
        unique case (r_cmd)
            CMD_LOAD_A:   err = (r_row >= IDX_W'(na)) || (r_col >= IDX_W'(na));
            CMD_LOAD_B:   err = (r_row >= IDX_W'(nb)) || (r_col >= IDX_W'(nb));
            CMD_FINALIZE: err = 1'b0;
            CMD_QUERY: begin
                if (!r_mode) begin
                    err = (DIM_W'(r_row) >= dim) || (DIM_W'(r_col) >= dim);
                end else begin
                    err = !r_list_ready || (CNT_W'(r_row) >= r_pair_total)
                       || (CNT_W'(r_col) >= r_pair_total);
                end
            end
            CMD_PAIR:     err = !r_list_ready || (CNT_W'(r_row) >= r_pair_total);
            default:      err = 1'b1;
        endcase
    end

    always_comb begin
        o_status.cmd        = r_cmd;
        o_status.mode       = r_mode;
        o_status.err        = err;
        o_status.same_idx   = (r_row == r_col);
        o_status.fin_b_last = (32'(r_fin_b) + 1 == 32'(nb));
        o_status.fin_a_last = (32'(r_fin_a) + 1 == 32'(na));
    end

    // Store read address selection
    always_comb begin
        a_re       = 1'b0;
        b_re       = 1'b0;
        list_re    = 1'b0;
        a_raddr    = '0;
        b_raddr    = '0;
        list_raddr = '0;
        unique case (i_op)
            OP_RD_IK: begin
                a_re    = 1'b1;
                b_re    = 1'b1;
                a_raddr = f_addr(node_i, node_i);
                b_raddr = f_addr(node_k, node_k);
            end
            OP_RD_JL: begin
                a_re    = 1'b1;
                b_re    = 1'b1;
                a_raddr = f_addr(node_j, node_j);
                b_raddr = f_addr(node_l, node_l);
            end
            OP_RD_EDGE: begin
                a_re    = 1'b1;
                b_re    = 1'b1;
                a_raddr = f_addr(node_i, node_j);
                b_raddr = f_addr(node_k, node_l);
            end
            OP_RD_LIST_HI: begin
                list_re    = 1'b1;
                list_raddr = idx_hi;
            end
            OP_RD_LIST_LO: begin
                list_re    = 1'b1;
                list_raddr = idx_lo;
            end
            OP_RD_LIST_ROW: begin
                list_re    = 1'b1;
                list_raddr = r_row;
            end
            OP_RD_PAIR_EDGE: begin
                a_re    = 1'b1;
                b_re    = 1'b1;
                a_raddr = f_addr(r_hi_pair[LW-1:NODE_W], list_rdata[LW-1:NODE_W]);
                b_raddr = f_addr(r_hi_pair[NODE_W-1:0], list_rdata[NODE_W-1:0]);
            end
            OP_FIN_RD_A: begin
                a_re    = 1'b1;
                a_raddr = f_addr(r_fin_a, r_fin_a);
            end
            OP_FIN_RD_B: begin
                b_re    = 1'b1;
                b_raddr = f_addr(r_fin_b, r_fin_b);
            end
            default: begin
            end
        endcase
    end

    assign a_we     = (i_op == OP_LOAD) && (r_cmd == CMD_LOAD_A);
    assign b_we     = (i_op == OP_LOAD) && (r_cmd == CMD_LOAD_B);
    assign ab_waddr = f_addr(NODE_W'(r_row), NODE_W'(r_col));

    assign labels_eq  = (a_rdata == b_rdata);
    assign a_positive = !a_rdata[LB-1] && (a_rdata != '0);
    assign a_sext     = LABEL_W'($signed(a_rdata));

    // The list stops growing once it holds the full capacity
    assign list_we = (i_op == OP_FIN_CMP) && labels_eq && !r_fin_cnt[CNT_W-1];

    lpga_ram #(.WIDTH(LB), .DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (ab_waddr),
        .i_wdata (r_label),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    lpga_ram #(.WIDTH(LB), .DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (ab_waddr),
        .i_wdata (r_label),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    lpga_ram #(.WIDTH(LW), .DEPTH(LIST_CAP)) u_pair_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (r_fin_cnt[LIST_AW-1:0]),
        .i_wdata ({r_fin_a, r_fin_b}),
        .i_re    (list_re),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    // Configuration and list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_size_a     <= SIZE_W'(SIZE_RESET);
            r_size_b     <= SIZE_W'(SIZE_RESET);
            r_pair_total <= '0;
            r_list_ready <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODE: r_mode <= i_cfg_data[0];
                    REG_SIZE_A: begin
                        r_size_a     <= i_cfg_data;
                        r_pair_total <= '0;
                        r_list_ready <= 1'b0;
                    end
                    REG_SIZE_B: begin
                        r_size_b     <= i_cfg_data;
                        r_pair_total <= '0;
                        r_list_ready <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_op == OP_LOAD) begin
                r_pair_total <= '0;
                r_list_ready <= 1'b0;
            end else if (i_op == OP_FIN_END) begin
                r_pair_total <= r_fin_cnt;
                r_list_ready <= 1'b1;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LATCH: begin
                r_cmd   <= i_cmd;
                r_row   <= i_row;
                r_col   <= i_col;
                r_label <= i_label[LB-1:0];
                r_quo_r <= i_row;
                r_rem_r <= '0;
                r_quo_c <= i_col;
                r_rem_c <= '0;
            end
            OP_DIV_STEP: begin
                r_quo_r <= {r_quo_r[IDX_W-2:0], ge_r};
                r_rem_r <= rem_next_r;
                r_quo_c <= {r_quo_c[IDX_W-2:0], ge_c};
                r_rem_c <= rem_next_c;
            end
            OP_RD_JL:      r_match_ik <= labels_eq;
            OP_RD_EDGE:    r_match_jl <= labels_eq;
            OP_RD_LIST_LO: r_hi_pair  <= list_rdata;
            OP_FIN_START: begin
                r_fin_a   <= '0;
                r_fin_b   <= '0;
                r_fin_cnt <= '0;
            end
            OP_FIN_CMP: begin
                if (list_we) begin
                    r_fin_cnt <= r_fin_cnt + 1'b1;
                end
                if (o_status.fin_b_last) begin
                    r_fin_b <= '0;
                    r_fin_a <= r_fin_a + 1'b1;
                end else begin
                    r_fin_b <= r_fin_b + 1'b1;
                end
            end
            OP_FULL_RES: begin
                r_out_value  <= (r_match_ik && r_match_jl && labels_eq && a_positive)
                              ? a_sext : '0;
                r_out_count  <= r_pair_total;
                r_out_node_a <= '0;
                r_out_node_b <= '0;
                r_out_err    <= 1'b0;
            end
            OP_CMP_RES: begin
                r_out_value  <= labels_eq ? a_sext : '0;
                r_out_count  <= r_pair_total;
                r_out_node_a <= '0;
                r_out_node_b <= '0;
                r_out_err    <= 1'b0;
            end
            OP_PAIR_RES: begin
                r_out_value  <= '0;
                r_out_count  <= r_pair_total;
                r_out_node_a <= NODE_OUT_W'(32'(list_rdata[LW-1:NODE_W]) + 1);
                r_out_node_b <= NODE_OUT_W'(32'(list_rdata[NODE_W-1:0]) + 1);
                r_out_err    <= 1'b0;
            end
            OP_RES_BASIC: begin
                r_out_value  <= '0;
                r_out_count  <= r_pair_total;
                r_out_node_a <= '0;
                r_out_node_b <= '0;
                r_out_err    <= err;
            end
            default: begin
            end
        endcase
    end

    assign o_value      = r_out_value;
    assign o_pair_count = r_out_count;
    assign o_node_a     = r_out_node_a;
    assign o_node_b     = r_out_node_b;
    assign o_error      = r_out_err;

endmodule

`default_nettype wire

### rtl/lpga_ctrl.sv
// Controller state machine: sequences store reads, division and the finalize scan.
`default_nettype none

module lpga_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_out_ready,
    input  wire lpga_pkg::t_dp_status i_status,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output lpga_pkg::t_dp_op          o_op
);

    import lpga_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_RES_BASIC,
        S_DIV,
        S_RD_IK,
        S_RD_JL,
        S_RD_EDGE,
        S_FULL_RES,
        S_LIST_HI,
        S_LIST_LO,
        S_PAIR_EDGE,
        S_CMP_RES,
        S_LIST_ROW,
        S_PAIR_RES,
        S_FIN_START,
        S_FIN_A,
        S_FIN_B,
        S_FIN_CMP,
        S_FIN_END
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [DIV_CNT_W-1:0]  n_div_cnt;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.cmd)
                    CMD_LOAD_A, CMD_LOAD_B: begin
                        n_state = i_status.err ? S_RES_BASIC : S_LOAD;
                    end
                    CMD_FINALIZE: n_state = S_FIN_START;
                    CMD_QUERY: begin
                        if (i_status.err) begin
                            n_state = S_RES_BASIC;
                        end else if (!i_status.mode) begin
                            n_state = S_DIV;
                        end else if (i_status.same_idx) begin
                            n_state = S_RES_BASIC;
                        end else begin
                            n_state = S_LIST_HI;
                        end
                    end
                    CMD_PAIR: n_state = i_status.err ? S_RES_BASIC : S_LIST_ROW;
                    default:  n_state = S_RES_BASIC;
                endcase
            end
            S_LOAD: begin
                o_op    = OP_LOAD;
                n_state = S_RES_BASIC;
            end
            S_DIV: begin
                o_op      = OP_DIV_STEP;
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_CNT_W'(IDX_W - 1)) begin
                    n_state = S_RD_IK;
                end
            end
            S_RD_IK: begin
                o_op    = OP_RD_IK;
                n_state = S_RD_JL;
            end
            S_RD_JL: begin
                o_op    = OP_RD_JL;
                n_state = S_RD_EDGE;
            end
            S_RD_EDGE: begin
                o_op    = OP_RD_EDGE;
                n_state = S_FULL_RES;
            end
            S_LIST_HI: begin
                o_op    = OP_RD_LIST_HI;
                n_state = S_LIST_LO;
            end
            S_LIST_LO: begin
                o_op    = OP_RD_LIST_LO;
                n_state = S_PAIR_EDGE;
            end
            S_PAIR_EDGE: begin
                o_op    = OP_RD_PAIR_EDGE;
                n_state = S_CMP_RES;
            end
            S_LIST_ROW: begin
                o_op    = OP_RD_LIST_ROW;
                n_state = S_PAIR_RES;
            end
            S_FIN_START: begin
                o_op    = OP_FIN_START;
                n_state = S_FIN_A;
            end
            S_FIN_A: begin
                o_op    = OP_FIN_RD_A;
                n_state = S_FIN_B;
            end
            S_FIN_B: begin
                o_op    = OP_FIN_RD_B;
                n_state = S_FIN_CMP;
            end
            S_FIN_CMP: begin
                o_op = OP_FIN_CMP;
                if (!i_status.fin_b_last) begin
                    n_state = S_FIN_B;
                end else if (!i_status.fin_a_last) begin
                    n_state = S_FIN_A;
                end else begin
                    n_state = S_FIN_END;
                end
            end
            S_FIN_END: begin
                o_op    = OP_FIN_END;
                n_state = S_RES_BASIC;
            end
            S_RES_BASIC, S_FULL_RES, S_CMP_RES, S_PAIR_RES: begin
                // The result is written straight into the output register,
                // so it waits here until that register is free.
                if (out_free) begin
                    unique case (r_state)
                        S_FULL_RES: o_op = OP_FULL_RES;
                        S_CMP_RES:  o_op = OP_CMP_RES;
                        S_PAIR_RES: o_op = OP_PAIR_RES;
                        default:    o_op = OP_RES_BASIC;
                    endcase
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted request did not move to decode");

    a_valid_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_op == OP_FULL_RES || o_op == OP_CMP_RES
                                     || o_op == OP_PAIR_RES || o_op == OP_RES_BASIC))
        else $error("output valid raised without a result operation");

    a_div_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_div_cnt == '0))
        else $error("divider step counter not cleared outside division");
`endif

endmodule

`default_nettype wire

### rtl/labeled_product_graph_adjacency.sv
// Top level of the labeled direct product graph adjacency engine.
// Rejected requests and unknown commands go straight to the result; a full product read runs
// 8 divider steps before its store reads. One request is in work at a time; the next is
// accepted once its result is registered, and the result waits while the output stalls.
// Reset is synchronous, active low: mode 0, sizes 16, pair list empty; stores are not cleared.
`default_nettype none

module labeled_product_graph_adjacency #(
    parameter int MAX_NODES  = lpga_pkg::DEF_MAX_NODES,
    parameter int LABEL_BITS = lpga_pkg::DEF_LABEL_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Request stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata, lowest bit first: row[7:0], col[15:8], label[31:16]
    input  wire logic [lpga_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: command[2:0]
    input  wire logic [lpga_pkg::CMD_W-1:0]          s_axis_tuser,
    // Result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata, lowest bit first: value[15:0], pair_count[24:16], node_a[29:25],
    // node_b[34:30], error[35], zero fill[39:36]
    output logic [lpga_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [lpga_pkg::REG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lpga_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import lpga_pkg::*;

    localparam int OUT_USED_W = LABEL_W + CNT_W + 2 * NODE_OUT_W + 1;

    t_dp_op                   op;
    t_dp_status               status;
    logic signed [LABEL_W-1:0] res_value;
    logic [CNT_W-1:0]          res_count;
    logic [NODE_OUT_W-1:0]     res_node_a;
    logic [NODE_OUT_W-1:0]     res_node_b;
    logic                      res_error;

    // The controller steps through the store reads of one request; the
    // datapath holds the stores, the divider and the output register.
    lpga_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_op        (op)
    );

    lpga_dp #(
        .MAX_NODES  (MAX_NODES),
        .LABEL_BITS (LABEL_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (s_axis_tuser),
        .i_row        (s_axis_tdata[IDX_W-1:0]),
        .i_col        (s_axis_tdata[2*IDX_W-1:IDX_W]),
        .i_label      (s_axis_tdata[2*IDX_W+LABEL_W-1:2*IDX_W]),
        .i_op         (op),
        .o_status     (status),
        .o_value      (res_value),
        .o_pair_count (res_count),
        .o_node_a     (res_node_a),
        .o_node_b     (res_node_b),
        .o_error      (res_error)
    );

    // Result fields packed from the lowest bit up, zero filled to whole bytes.
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                           res_error, res_node_b, res_node_a, res_count, res_value};

endmodule

`default_nettype wire

### test/labeled_product_graph_adjacency_test.sv
// Self-checking stream testbench for the labeled product graph adjacency engine.
`timescale 1ns / 1ps

module labeled_product_graph_adjacency_test;
    import lpga_pkg::*;

    // Graph stores are indexed row * NODES + col, as in the block.
    localparam int NODES = DEF_MAX_NODES;
    localparam int STORE_DEPTH = NODES * NODES;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    // Random requests per configuration phase.
    localparam int unsigned PHASE_REQUESTS = 70;
    localparam int unsigned DIRECTED_PHASES = 10;
    localparam int unsigned RANDOM_PHASES = 4;

    // Command codes 5 to 7 have no function; the block flags them as errors.
    localparam t_cmd CMD_UNDEF_FIRST = CMD_PAIR + 3'd1;
    localparam t_cmd CMD_UNDEF_LAST  = '1;

    // One request as it travels on the request stream.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [15:0] label;
    } t_request;

    // One result, in the order of the fields in the result tdata.
    typedef struct packed {
        logic [15:0] value;
        logic [8:0]  pair_count;
        logic [4:0]  node_a;
        logic [4:0]  node_b;
        logic        error;
    } t_answer;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [CMD_W-1:0]        s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    labeled_product_graph_adjacency dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Our own copy of the engine: configuration, label stores and pair list.
    // The stores read as zero until written, but the stimulus fills them all
    // before the first request that reads one.
    logic                    mode_reg = 1'b0;
    logic [4:0]              size_a_reg = 5'd16;
    logic [4:0]              size_b_reg = 5'd16;
    logic signed [15:0]      graph_a [0:STORE_DEPTH-1];
    logic signed [15:0]      graph_b [0:STORE_DEPTH-1];
    logic [7:0]              pair_node_a [0:LIST_CAP-1];
    logic [7:0]              pair_node_b [0:LIST_CAP-1];
    logic [8:0]              pair_total = '0;
    logic                    list_ready = 1'b0;

    t_request                pending_requests [$];
    t_answer                 answers_due [$];
    t_request                cur_req = '0;
    int unsigned             requests_presented = 0;
    int unsigned             requests_taken = 0;
    bit                      steady_flow = 1'b0;
    int unsigned             gap_left = 0;
    int unsigned             stall_left = 0;
    int unsigned             requests_queued = 0;
    int unsigned             results_seen = 0;
    int unsigned             mismatches = 0;
    int unsigned             cycle_count = 0;

    initial begin
        for (int n = 0; n < STORE_DEPTH; n++) begin
            graph_a[n] = '0;
            graph_b[n] = '0;
        end
        for (int n = 0; n < LIST_CAP; n++) begin
            pair_node_a[n] = '0;
            pair_node_b[n] = '0;
        end
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A size of zero acts as one node and sizes above the store act as the store.
    function automatic int unsigned effective_nodes(input logic [4:0] size);
        if (size == 0) return 1;
        if (size > NODES) return NODES;
        return 32'(size);
    endfunction

    // Applies one configuration write to our copy. Size writes drop the pair list,
    // a mode write keeps it.
    task automatic apply_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        unique case (idx)
            REG_MODE: begin
                mode_reg = data[0];
            end
            REG_SIZE_A: begin
                size_a_reg = data;
                list_ready = 1'b0;
                pair_total = '0;
            end
            REG_SIZE_B: begin
                size_b_reg = data;
                list_ready = 1'b0;
                pair_total = '0;
            end
            default: begin
            end
        endcase
    endtask

    // Works out the single result that one accepted request produces and
    // updates our copy of the engine state on the way.
    task automatic derive_product_answer(input t_request r);
        t_answer            ans;
        int unsigned        na, nb, n, dim, i, j, k, l, lo, hi, cnt;
        logic signed [15:0] ea, eb;
        ans = '0;
        na = effective_nodes(size_a_reg);
        nb = effective_nodes(size_b_reg);
        unique case (r.cmd)
            CMD_LOAD_A, CMD_LOAD_B: begin
                n = (r.cmd == CMD_LOAD_A) ? na : nb;
                if (r.row >= n || r.col >= n) begin
                    ans.error = 1'b1;
                end else begin
                    if (r.cmd == CMD_LOAD_A) begin
                        graph_a[r.row * NODES + r.col] = r.label;
                    end else begin
                        graph_b[r.row * NODES + r.col] = r.label;
                    end
                    list_ready = 1'b0;
                    pair_total = '0;
                end
            end
            CMD_FINALIZE: begin
                // Pairs are listed with the first graph's node as the outer loop.
                cnt = 0;
                for (int a = 0; a < na; a++) begin
                    for (int b = 0; b < nb; b++) begin
                        if (cnt < LIST_CAP &&
                            graph_a[a * NODES + a] == graph_b[b * NODES + b]) begin
                            pair_node_a[cnt] = 8'(a);
                            pair_node_b[cnt] = 8'(b);
                            cnt++;
                        end
                    end
                end
                pair_total = 9'(cnt);
                list_ready = 1'b1;
            end
            CMD_QUERY: begin
                if (!mode_reg) begin
                    // Full product: both node pairs must match and the edge labels
                    // must agree and be positive.
                    dim = na * nb;
                    if (r.row >= dim || r.col >= dim) begin
                        ans.error = 1'b1;
                    end else begin
                        i = r.row / nb;
                        k = r.row % nb;
                        j = r.col / nb;
                        l = r.col % nb;
                        if (graph_a[i * NODES + i] == graph_b[k * NODES + k] &&
                            graph_a[j * NODES + j] == graph_b[l * NODES + l]) begin
                            ea = graph_a[i * NODES + j];
                            eb = graph_b[k * NODES + l];
                            if (ea == eb && ea > 0) ans.value = ea;
                        end
                    end
                end else begin
                    // Compressed product: entries between listed pairs, zero on the
                    // diagonal, the lower triangle of both graphs is read.
                    if (!list_ready || r.row >= pair_total || r.col >= pair_total) begin
                        ans.error = 1'b1;
                    end else if (r.row != r.col) begin
                        lo = (r.row < r.col) ? r.row : r.col;
                        hi = (r.row < r.col) ? r.col : r.row;
                        ea = graph_a[pair_node_a[hi] * NODES + pair_node_a[lo]];
                        eb = graph_b[pair_node_b[hi] * NODES + pair_node_b[lo]];
                        if (ea == eb) ans.value = ea;
                    end
                end
            end
            CMD_PAIR: begin
                if (!list_ready || r.row >= pair_total) begin
                    ans.error = 1'b1;
                end else begin
                    ans.node_a = 5'(pair_node_a[r.row] + 8'd1);
                    ans.node_b = 5'(pair_node_b[r.row] + 8'd1);
                end
            end
            default: begin
                ans.error = 1'b1;
            end
        endcase
        ans.pair_count = pair_total;
        answers_due = {answers_due, ans};
    endtask

    task automatic report_mismatch(input string field, input logic [OUT_TDATA_W-1:0] got,
                                   input logic [OUT_TDATA_W-1:0] want);
        $display("Mismatch at result %0d: %s is %0h, expected %0h",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Node labels come from a small set so that pairs match often; edge labels
    // cluster around zero so that equal labels of both signs show up. A share of
    // full-range and extreme labels exercises every bit.
    function automatic logic [15:0] pick_label(input bit on_diag);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return 16'($urandom_range(0, 16'hFFFF));
        if (roll < 10) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if (on_diag) return 16'($urandom_range(1, 3));
        return 16'(int'($urandom_range(0, 3)) - 1);
    endfunction

    task automatic queue_request(input t_cmd cmd, input int unsigned row,
                                 input int unsigned col, input logic [15:0] label);
        t_request r;
        r.cmd = cmd;
        r.row = 8'(row);
        r.col = 8'(col);
        r.label = label;
        pending_requests = {pending_requests, r};
        requests_queued++;
    endtask

    // Returns once every queued request has been taken and answered.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_requests.size() != 0 || s_axis_tvalid || answers_due.size() != 0);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        apply_reg(idx, data);
    endtask

    // One well-formed stretch: a few loads, usually a finalize, then a run of
    // product queries and pair reads, sprinkled with malformed requests.
    task automatic run_burst();
        int unsigned na, nb, n, lim, row, col, roll;
        t_cmd        load_cmd;
        na = effective_nodes(size_a_reg);
        nb = effective_nodes(size_b_reg);
        repeat ($urandom_range(0, 6)) begin
            load_cmd = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
            n = (load_cmd == CMD_LOAD_A) ? na : nb;
            if ($urandom_range(0, 9) == 0) begin
                row = $urandom_range(0, 255);
                col = $urandom_range(n, 255);
                if ($urandom_range(0, 1)) begin
                    queue_request(load_cmd, col, row, pick_label(1'b0));
                end else begin
                    queue_request(load_cmd, row, col, pick_label(1'b0));
                end
            end else begin
                row = $urandom_range(0, n - 1);
                col = ($urandom_range(0, 9) < 3) ? row : $urandom_range(0, n - 1);
                queue_request(load_cmd, row, col, pick_label(row == col));
            end
        end
        if ($urandom_range(0, 99) < 85) begin
            queue_request(CMD_FINALIZE, $urandom_range(0, 255), $urandom_range(0, 255),
                          16'($urandom_range(0, 16'hFFFF)));
            // The pair count steers the query indices, so let the list settle.
            wait_drained();
        end
        repeat ($urandom_range(8, 30)) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                lim = mode_reg ? pair_total : na * nb;
                if (lim == 0 || roll < 5) begin
                    row = $urandom_range(0, 255);
                    col = $urandom_range(0, 255);
                end else begin
                    row = $urandom_range(0, lim - 1);
                    col = ($urandom_range(0, 9) == 0) ? row : $urandom_range(0, lim - 1);
                end
                queue_request(CMD_QUERY, row, col, 16'($urandom_range(0, 16'hFFFF)));
            end else if (roll < 90) begin
                if (pair_total == 0 || roll < 55) begin
                    row = $urandom_range(0, 255);
                end else begin
                    row = $urandom_range(0, pair_total - 1);
                end
                queue_request(CMD_PAIR, row, $urandom_range(0, 255),
                              16'($urandom_range(0, 16'hFFFF)));
            end else if (roll < 95) begin
                queue_request(t_cmd'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST)),
                              $urandom_range(0, 255), $urandom_range(0, 255),
                              16'($urandom_range(0, 16'hFFFF)));
            end else begin
                // A stray load in the middle of the queries drops the list.
                queue_request(CMD_LOAD_A, $urandom_range(0, na - 1), $urandom_range(0, na - 1),
                              pick_label(1'b0));
            end
        end
    endtask

    // Request driver: presents the next pending request after its gap and holds
    // it until the block takes it.
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || requests_taken == requests_presented) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                cur_req = pending_requests.pop_front();
                requests_presented++;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {cur_req.label, cur_req.col, cur_req.row};
                s_axis_tuser <= cur_req.cmd;
                gap_left = steady_flow ? 0 : pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls, none in the steady phases.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = steady_flow ? 0 : pick_gap();
        end
    end

    // A request is taken at this edge: predict what it must return.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            derive_product_answer(cur_req);
            requests_taken++;
        end
    end

    // Result monitor: each result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[24:16], m_axis_tdata[29:25],
                   m_axis_tdata[34:30], m_axis_tdata[35]};
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, '0);
            end else begin
                want = answers_due.pop_front();
                if (got.value !== want.value) begin
                    report_mismatch("value", OUT_TDATA_W'(got.value),
                                    OUT_TDATA_W'(want.value));
                end
                if (got.pair_count !== want.pair_count) begin
                    report_mismatch("pair_count", OUT_TDATA_W'(got.pair_count),
                                    OUT_TDATA_W'(want.pair_count));
                end
                if (got.node_a !== want.node_a) begin
                    report_mismatch("node_a", OUT_TDATA_W'(got.node_a),
                                    OUT_TDATA_W'(want.node_a));
                end
                if (got.node_b !== want.node_b) begin
                    report_mismatch("node_b", OUT_TDATA_W'(got.node_b),
                                    OUT_TDATA_W'(want.node_b));
                end
                if (got.error !== want.error) begin
                    report_mismatch("error", OUT_TDATA_W'(got.error), OUT_TDATA_W'(want.error));
                end
                if (m_axis_tdata[39:36] !== '0) begin
                    report_mismatch("zero fill", OUT_TDATA_W'(m_axis_tdata[39:36]), '0);
                end
            end
            results_seen++;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Configurations walked after the opening full-size phase: mode, size_a, size_b.
    // Size zero and 31 stand for one node and a full store.
    int unsigned plan_mode [DIRECTED_PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1, 0, 1};
    int unsigned plan_size_a [DIRECTED_PHASES] = '{16, 0, 31, 1, 7, 4, 16, 2, 16, 16};
    int unsigned plan_size_b [DIRECTED_PHASES] = '{16, 5, 3, 1, 9, 16, 1, 2, 16, 16};

    initial begin
        int unsigned phase_start, m, sa, sb;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Opening phase: reset values written explicitly, full 16 x 16 graphs.
        write_reg(REG_MODE, 5'd0);
        write_reg(REG_SIZE_A, 5'd16);
        write_reg(REG_SIZE_B, 5'd16);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;

        // Requests that touch no store: pair read before any finalize, the
        // unused command codes and loads outside the graph.
        queue_request(CMD_PAIR, 0, 0, 16'h0000);
        queue_request(CMD_UNDEF_FIRST, 255, 255, 16'hFFFF);
        queue_request(CMD_UNDEF_FIRST + 3'd1, 0, 0, 16'h0000);
        queue_request(CMD_UNDEF_LAST, 170, 85, 16'h5A5A);
        queue_request(CMD_LOAD_A, NODES, 0, 16'h1234);
        queue_request(CMD_LOAD_B, 0, 255, 16'hA5A5);
        queue_request(CMD_LOAD_A, 255, 255, 16'h7FFF);

        // Fill both stores completely. All node labels equal, so the finalize
        // that follows lists the full 256 pairs.
        for (int r = 0; r < NODES; r++) begin
            for (int c = 0; c < NODES; c++) begin
                queue_request(CMD_LOAD_A, r, c, (r == c) ? 16'h0001 : pick_label(1'b0));
                queue_request(CMD_LOAD_B, r, c, (r == c) ? 16'h0001 : pick_label(1'b0));
            end
        end

        // Extreme edge labels: the most negative one matches but is not positive,
        // the most positive one passes in both modes.
        queue_request(CMD_LOAD_A, 1, 0, 16'h8000);
        queue_request(CMD_LOAD_B, 1, 0, 16'h8000);
        queue_request(CMD_LOAD_A, 2, 0, 16'h7FFF);
        queue_request(CMD_LOAD_B, 2, 0, 16'h7FFF);
        queue_request(CMD_FINALIZE, 0, 0, 16'h0000);
        queue_request(CMD_PAIR, 0, 0, 16'h0000);
        queue_request(CMD_PAIR, 255, 0, 16'h0000);
        queue_request(CMD_QUERY, 17, 0, 16'h0000);
        queue_request(CMD_QUERY, 34, 0, 16'h0000);
        queue_request(CMD_QUERY, 255, 255, 16'h0000);
        queue_request(CMD_QUERY, 0, 0, 16'h0000);

        for (int p = 0; p < DIRECTED_PHASES + RANDOM_PHASES; p++) begin
            wait_drained();
            repeat (2) @(negedge i_clk);
            if (p < DIRECTED_PHASES) begin
                m = plan_mode[p];
                sa = plan_size_a[p];
                sb = plan_size_b[p];
            end else begin
                m = $urandom_range(0, 1);
                sa = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
                sb = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
            end
            // The upper bits of a mode write are don't-care and are randomized.
            write_reg(REG_MODE, {4'($urandom_range(0, 15)), m[0]});
            // The first switch changes the mode alone, so the list stays ready.
            if (p != 0) begin
                write_reg(REG_SIZE_A, 5'(sa));
                write_reg(REG_SIZE_B, 5'(sb));
            end
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            steady_flow = (p % 4 == 2);
            if (p == 0) begin
                // Compressed reads over the full list: the lower-triangle edges,
                // the zero diagonal and the far corner of the list.
                queue_request(CMD_QUERY, 17, 0, 16'h0000);
                queue_request(CMD_QUERY, 0, 34, 16'h0000);
                queue_request(CMD_QUERY, 5, 5, 16'h0000);
                queue_request(CMD_QUERY, 255, 254, 16'h0000);
            end
            phase_start = requests_queued;
            while (requests_queued - phase_start < PHASE_REQUESTS) begin
                run_burst();
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/lpga_pkg.sv
rtl/lpga_ram.sv
rtl/lpga_dp.sv
rtl/lpga_ctrl.sv
rtl/labeled_product_graph_adjacency.sv
test/labeled_product_graph_adjacency_test.sv
